@@ rtl/core/afsk_uart_bit_modulator_assert.svh @@
`ifndef AFSK_UART_BIT_MODULATOR_ASSERT_SVH
`define AFSK_UART_BIT_MODULATOR_ASSERT_SVH

// General property check, clocked on clk and disabled while in reset.
`define AFSK_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("afsk check failed");

// A signal must hold while its transaction is stalled.
`define AFSK_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> $stable(sig)) \
        else $error("afsk stall hold failed");

`endif

@@ rtl/core/afsk_pkg.sv @@
package afsk_pkg;

    localparam int SAMPLES_PER_BIT_N_DEF = 20;
    localparam int QUEUE_DEPTH           = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PHASE_W    = 16;
    localparam int FRAME_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MARK_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEVEN_BIT_DATA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_EVEN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_STOP       = 3'd5;

    localparam logic [PHASE_W-1:0] MARK_STEP_RST  = 16'd3277;
    localparam logic [PHASE_W-1:0] SPACE_STEP_RST = 16'd6008;

    typedef struct packed {
        logic       byte_available;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [14:0] phase_angle;
        logic        tone_mark;
        logic        byte_taken;
        logic        last_sample;
    } sample_t;

    typedef struct packed {
        logic [PHASE_W-1:0] mark_step;
        logic [PHASE_W-1:0] space_step;
        logic               seven_bit_data;
        logic               parity_enable;
        logic               parity_even;
        logic               two_stop;
    } cfg_t;

    // One bit period as handed from the front end to the sample generator.
    typedef struct packed {
        logic tone_mark;
        logic byte_taken;
    } period_t;

    // Frame layout from the top bit down: start, data MSB first, parity, stop bits.
    function automatic logic [FRAME_W-1:0] build_frame(input logic [7:0] c, input cfg_t cfg);
        logic [FRAME_W-1:0] f;
        logic [7:0]         d;
        logic               par;
        logic [3:0]         pos;
        d   = cfg.seven_bit_data ? {1'b0, c[6:0]} : c;
        par = (^d) ^ ~cfg.parity_even;
        f   = '0;
        if (cfg.seven_bit_data)
        begin
            f[14:8] = d[6:0];
            pos     = 4'd7;
        end
        else
        begin
            f[14:7] = d;
            pos     = 4'd6;
        end
        if (cfg.parity_enable)
        begin
            f[pos] = par;
            pos    = pos - 4'd1;
        end
        f[pos] = 1'b1;
        if (cfg.two_stop)
        begin
            f[pos - 4'd1] = 1'b1;
        end
        return f;
    endfunction

endpackage

@@ rtl/core/afsk_stream_if.sv @@
interface afsk_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/afsk_front.sv @@
module afsk_front (
    input  logic              clk,
    input  logic              rst_n,
    afsk_stream_if.sink       bit_req,
    input  afsk_pkg::cfg_t    cfg,
    output logic              push_valid,
    output afsk_pkg::period_t push_data,
    input  logic              push_ready
);
    import afsk_pkg::*;

    logic [FRAME_W-1:0] frame_shift_reg;
    logic [FRAME_W-1:0] frame_shift_next;
    logic [FRAME_W-1:0] frame_loaded;
    logic               load;
    logic               accept;

    assign bit_req.ready = push_ready;
    assign accept        = bit_req.valid && push_ready;

    // Frame a new byte only when the previous frame has fully shifted out.
    assign load             = (frame_shift_reg == '0) && bit_req.payload.byte_available;
    assign frame_loaded     = load ? build_frame(bit_req.payload.data_byte, cfg) : frame_shift_reg;
    assign frame_shift_next = {frame_loaded[FRAME_W-2:0], 1'b0};

    assign push_valid           = bit_req.valid;
    assign push_data.tone_mark  = (frame_loaded == '0) || frame_loaded[FRAME_W-1];
    assign push_data.byte_taken = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg <= '0;
        end
        else if (accept)
        begin
            frame_shift_reg <= frame_shift_next;
        end
    end

endmodule

@@ rtl/core/afsk_queue.sv @@
module afsk_queue #(
    parameter int DEPTH = afsk_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  afsk_pkg::period_t push_data,
    output logic              push_ready,
    output logic              pop_valid,
    output afsk_pkg::period_t pop_data,
    input  logic              pop
);
    import afsk_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    period_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ rtl/core/afsk_back.sv @@
module afsk_back #(
    parameter int SAMPLES_PER_BIT_N = afsk_pkg::SAMPLES_PER_BIT_N_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  afsk_pkg::cfg_t    cfg,
    input  logic              head_valid,
    input  afsk_pkg::period_t head,
    output logic              pop,
    afsk_stream_if.source     sample
);
    import afsk_pkg::*;

    localparam int               CNT_W = (SAMPLES_PER_BIT_N > 1) ? $clog2(SAMPLES_PER_BIT_N) : 1;
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(SAMPLES_PER_BIT_N - 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic [PHASE_W-1:0] acc_reg;
    logic [PHASE_W-1:0] acc_next;
    logic [PHASE_W-1:0] step;
    logic               valid_reg;
    sample_t            sample_reg;
    logic               advance;
    logic               last;

    // Advance one sample whenever a period is queued and the output register is free or being drained.
    assign advance  = head_valid && (!valid_reg || sample.ready);
    assign last     = (cnt_reg == LAST);
    assign pop      = advance && last;
    assign step     = head.tone_mark ? cfg.mark_step : cfg.space_step;
    assign acc_next = acc_reg + step;

    assign sample.valid   = valid_reg;
    assign sample.payload = sample_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_reg.phase_angle <= acc_next[PHASE_W-1:1];
            sample_reg.tone_mark   <= head.tone_mark;
            sample_reg.byte_taken  <= head.byte_taken;
            sample_reg.last_sample <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            cnt_reg   <= last ? '0 : cnt_reg + 1'b1;
            acc_reg   <= acc_next;
            valid_reg <= 1'b1;
        end
        else if (sample.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/core/afsk_uart_bit_modulator.sv @@
// Once a request is accepted with the queue empty, its first sample passes through the queue entry
// register and then the sample output register.
// Throughput: one sample per cycle while a period is queued and the sample output is not stalled,
// SAMPLES_PER_BIT_N samples (20 by default) per request, set by the sample generator.
// A two-entry queue lets requests be taken while samples of earlier periods still stream out.
// Reset: configuration returns to its defaults, frame register, phase accumulator and queue
// clear, and no sample is valid.
module afsk_uart_bit_modulator #(
    parameter int SAMPLES_PER_BIT_N = afsk_pkg::SAMPLES_PER_BIT_N_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    afsk_stream_if.sink                     bit_req,
    afsk_stream_if.source                   sample,
    input  logic                            cfg_we,
    input  logic [afsk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afsk_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import afsk_pkg::*;

    cfg_t    cfg_reg;
    logic    push_valid;
    logic    push_ready;
    period_t push_data;
    logic    head_valid;
    period_t head;
    logic    pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mark_step      <= MARK_STEP_RST;
            cfg_reg.space_step     <= SPACE_STEP_RST;
            cfg_reg.seven_bit_data <= 1'b0;
            cfg_reg.parity_enable  <= 1'b1;
            cfg_reg.parity_even    <= 1'b0;
            cfg_reg.two_stop       <= 1'b0;
        end
        else if (cfg_we)
        begin
            // Drop writes to unknown indexes.
            unique case (cfg_index)
                CFG_MARK_STEP:      cfg_reg.mark_step      <= cfg_wdata[PHASE_W-1:0];
                CFG_SPACE_STEP:     cfg_reg.space_step     <= cfg_wdata[PHASE_W-1:0];
                CFG_SEVEN_BIT_DATA: cfg_reg.seven_bit_data <= cfg_wdata[0];
                CFG_PARITY_ENABLE:  cfg_reg.parity_enable  <= cfg_wdata[0];
                CFG_PARITY_EVEN:    cfg_reg.parity_even    <= cfg_wdata[0];
                CFG_TWO_STOP:       cfg_reg.two_stop       <= cfg_wdata[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    afsk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_req    (bit_req),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    afsk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (head_valid),
        .pop_data   (head),
        .pop        (pop)
    );

    afsk_back #(
        .SAMPLES_PER_BIT_N (SAMPLES_PER_BIT_N)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .sample     (sample)
    );

endmodule

@@ rtl/core/afsk_checker.sv @@
`include "afsk_uart_bit_modulator_assert.svh"

module afsk_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input afsk_pkg::sample_t out_payload
);

    `AFSK_ASSERT_HOLD(a_out_valid_hold, clk, rst_n, out_valid, out_ready, out_valid)
    `AFSK_ASSERT_HOLD(a_out_payload_hold, clk, rst_n, out_valid, out_ready, out_payload)

    // A period that takes a byte sends the start bit, which is always space.
    `AFSK_ASSERT(a_taken_is_space, clk, rst_n, out_valid |-> !(out_payload.byte_taken && out_payload.tone_mark))

    // Samples of one period follow back to back with the same tone and taken flag.
    `AFSK_ASSERT(a_period_continues, clk, rst_n, (out_valid && out_ready && !out_payload.last_sample) |=> (out_valid && $stable(out_payload.tone_mark) && $stable(out_payload.byte_taken)))

endmodule

bind afsk_uart_bit_modulator afsk_checker u_afsk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (sample.valid),
    .out_ready   (sample.ready),
    .out_payload (sample.payload)
);
